// ===== design/ws2812_pixel_serial_driver_defines.svh =====
// ----------------------------------------------------------------------------
// WS2812 pixel driver assertion macros
// Property shorthands for the checker file of the pixel driver.
// ----------------------------------------------------------------------------
`ifndef WS2812_PIXEL_SERIAL_DRIVER_DEFINES_SVH
`define WS2812_PIXEL_SERIAL_DRIVER_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define WPSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define WPSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/wpsd_pkg.sv =====
// ----------------------------------------------------------------------------
// WS2812 pixel driver package
// Payload types, register indexes and sizing constants of the pixel driver.
// ----------------------------------------------------------------------------
package wpsd_pkg;

  localparam int TIMING_W = 10;
  localparam int BRIGHT_W = 8;
  localparam int PIX_W    = 9;
  localparam int COLOR_W  = 8;
  localparam int WORD_W   = 24;
  localparam int BIDX_W   = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [PIX_W-1:0]  MAX_PIXELS = 9'd256;
  localparam logic [BIDX_W-1:0] LAST_BIT   = 5'd23;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_ZERO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_ONE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT = 3'd4;

  // Reset values of the registers.
  localparam logic [TIMING_W-1:0] RST_BIT_PERIOD  = 10'd120;
  localparam logic [TIMING_W-1:0] RST_HIGH_ZERO   = 10'd38;
  localparam logic [TIMING_W-1:0] RST_HIGH_ONE    = 10'd80;
  localparam logic [BRIGHT_W-1:0] RST_BRIGHTNESS  = 8'd255;
  localparam logic [PIX_W-1:0]    RST_PIXEL_COUNT = 9'd1;

  // Command codes of an input item.
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } in_t;

  typedef struct packed {
    logic pin_level;
    logic busy_res;
    logic refused;
  } out_t;

endpackage

// ===== design/wpsd_color_scale.sv =====
// ----------------------------------------------------------------------------
// WS2812 pixel driver color scaler
// Scales the three color bytes by the brightness factor and packs them GRB.
// ----------------------------------------------------------------------------
module wpsd_color_scale import wpsd_pkg::*; (
  input  logic [COLOR_W-1:0]  red,
  input  logic [COLOR_W-1:0]  green,
  input  logic [COLOR_W-1:0]  blue,
  input  logic [BRIGHT_W-1:0] brightness,
  output logic [WORD_W-1:0]   grb_word
);

  logic [COLOR_W+BRIGHT_W-1:0] red_prod;
  logic [COLOR_W+BRIGHT_W-1:0] green_prod;
  logic [COLOR_W+BRIGHT_W-1:0] blue_prod;

  // Three small 8x8 products in parallel; the top byte is the scaled color.
  assign red_prod   = red   * brightness;
  assign green_prod = green * brightness;
  assign blue_prod  = blue  * brightness;

  assign grb_word = {green_prod[COLOR_W+BRIGHT_W-1:BRIGHT_W],
                     red_prod[COLOR_W+BRIGHT_W-1:BRIGHT_W],
                     blue_prod[COLOR_W+BRIGHT_W-1:BRIGHT_W]};

endmodule

// ===== design/ws2812_pixel_serial_driver.sv =====
// ----------------------------------------------------------------------------
// WS2812 pixel serial driver
// The result of an input transfer is in the output register in the next cycle.
// Throughput: one item per cycle; the frame state and the result register are
// updated at the same edge, so ticks stream back to back while out_ready holds.
// Reset (rst_n low, synchronous): registers return to 120/38/80/255/1, the frame
// state is cleared to idle and the output register is emptied.
// ----------------------------------------------------------------------------
module ws2812_pixel_serial_driver import wpsd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers.
  logic [TIMING_W-1:0] bit_period_r;
  logic [TIMING_W-1:0] high_zero_r;
  logic [TIMING_W-1:0] high_one_r;
  logic [BRIGHT_W-1:0] brightness_r;
  logic [PIX_W-1:0]    pixel_count_r;

  // Frame state: the latched GRB word, the bit being sent (0 is the MSB),
  // the pixels still to go and the tick position inside the current bit.
  logic [WORD_W-1:0]   grb_r,      grb_nxt;
  logic [BIDX_W-1:0]   bit_idx_r,  bit_idx_nxt;
  logic [PIX_W-1:0]    pix_left_r, pix_left_nxt;
  logic [TIMING_W-1:0] tick_r,     tick_nxt;
  logic                sending_r,  sending_nxt;

  // Output register.
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r,  out_data_nxt;

  logic                in_xfer;
  logic [WORD_W-1:0]   scaled_word;
  logic [PIX_W-1:0]    pix_start;
  logic [BIDX_W-1:0]   cur_pos;
  logic [TIMING_W-1:0] cur_high;
  logic [TIMING_W-1:0] bit_len;
  logic [TIMING_W:0]   tick_inc;
  logic [BIDX_W-1:0]   nxt_pos;
  logic [TIMING_W-1:0] nxt_high;
  logic                refused;

  // The block takes an item whenever the output register is empty or its
  // result is being transferred out in this cycle.
  assign in_ready  = !out_valid_r || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Register writes. Timing registers act at once; brightness and pixel
  // count are only sampled by the next accepted color write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r  <= RST_BIT_PERIOD;
      high_zero_r   <= RST_HIGH_ZERO;
      high_one_r    <= RST_HIGH_ONE;
      brightness_r  <= RST_BRIGHTNESS;
      pixel_count_r <= RST_PIXEL_COUNT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BIT_PERIOD:  bit_period_r  <= cfg_wdata[TIMING_W-1:0];
        REG_HIGH_ZERO:   high_zero_r   <= cfg_wdata[TIMING_W-1:0];
        REG_HIGH_ONE:    high_one_r    <= cfg_wdata[TIMING_W-1:0];
        REG_BRIGHTNESS:  brightness_r  <= cfg_wdata[BRIGHT_W-1:0];
        REG_PIXEL_COUNT: pixel_count_r <= cfg_wdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  wpsd_color_scale u_scale (
    .red        (in_data.red),
    .green      (in_data.green),
    .blue       (in_data.blue),
    .brightness (brightness_r),
    .grb_word   (scaled_word)
  );

  // A pixel count beyond the chain limit is clamped to the limit.
  assign pix_start = (pixel_count_r > MAX_PIXELS) ? MAX_PIXELS : pixel_count_r;

  // High time of the bit now on the wire, and the bit length: the longer of
  // the period and the high time, and never shorter than one tick.
  assign cur_pos  = LAST_BIT - bit_idx_r;
  assign cur_high = grb_r[cur_pos] ? high_one_r : high_zero_r;
  always_comb begin
    bit_len = (cur_high > bit_period_r) ? cur_high : bit_period_r;
    if (bit_len == '0) begin
      bit_len = TIMING_W'(1);
    end
  end
  assign tick_inc = {1'b0, tick_r} + 1'b1;

  // Next frame state for the item at the input.
  always_comb begin
    grb_nxt      = grb_r;
    bit_idx_nxt  = bit_idx_r;
    pix_left_nxt = pix_left_r;
    tick_nxt     = tick_r;
    sending_nxt  = sending_r;
    refused      = 1'b0;
    if (in_data.cmd == CMD_WRITE) begin
      if (sending_r) begin
        // A write during a frame is dropped and does not advance time.
        refused = 1'b1;
      end else begin
        grb_nxt      = scaled_word;
        bit_idx_nxt  = '0;
        tick_nxt     = '0;
        pix_left_nxt = pix_start;
        sending_nxt  = (pix_start != '0);
      end
    end else if (sending_r) begin
      if (tick_inc < {1'b0, bit_len}) begin
        tick_nxt = tick_inc[TIMING_W-1:0];
      end else begin
        tick_nxt = '0;
        if (bit_idx_r == LAST_BIT) begin
          // End of a pixel: move to the next one, or close the frame.
          bit_idx_nxt = '0;
          if (pix_left_r != '0) begin
            pix_left_nxt = pix_left_r - 1'b1;
          end
          if (pix_left_r <= PIX_W'(1)) begin
            sending_nxt = 1'b0;
          end
        end else begin
          bit_idx_nxt = bit_idx_r + 1'b1;
        end
      end
    end
  end

  // The result shows the line level at the new position.
  assign nxt_pos  = LAST_BIT - bit_idx_nxt;
  assign nxt_high = grb_nxt[nxt_pos] ? high_one_r : high_zero_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (in_xfer) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.pin_level = sending_nxt && (tick_nxt < nxt_high);
      out_data_nxt.busy_res  = sending_nxt;
      out_data_nxt.refused   = refused;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grb_r       <= '0;
      bit_idx_r   <= '0;
      pix_left_r  <= '0;
      tick_r      <= '0;
      sending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_xfer) begin
        grb_r      <= grb_nxt;
        bit_idx_r  <= bit_idx_nxt;
        pix_left_r <= pix_left_nxt;
        tick_r     <= tick_nxt;
        sending_r  <= sending_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== design/wpsd_checker.sv =====
// ----------------------------------------------------------------------------
// WS2812 pixel driver checker
// Port-level properties of the pixel driver, bound to its top level.
// ----------------------------------------------------------------------------
`include "ws2812_pixel_serial_driver_defines.svh"

module wpsd_checker import wpsd_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // A stalled result holds still until it is transferred.
  `WPSD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // Every input transfer leaves a result in the output register.
  `WPSD_ASSERT_NEXT(a_result_follows, in_valid && in_ready, out_valid, "input transfer produced no result")

  // A write is only refused during a frame, which is still running.
  `WPSD_ASSERT_NOW(a_refused_busy, out_valid && out_data.refused, out_data.busy_res, "refused while idle")

  // The line is only driven high inside a frame.
  `WPSD_ASSERT_NOW(a_pin_busy, out_valid && out_data.pin_level, out_data.busy_res, "line high while idle")

endmodule

bind ws2812_pixel_serial_driver wpsd_checker u_wpsd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
